// ===== rtl/core/prefixed_integer_literal_parser_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the prefixed integer literal parser
// Concurrent checks compile to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef PREFIXED_INTEGER_LITERAL_PARSER_DEFINES_SVH
`define PREFIXED_INTEGER_LITERAL_PARSER_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define PLIP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
// next-cycle implication
`define PLIP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define PLIP_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PLIP_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/plip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// plip_pkg: shared types and constants
// Character classes, queue token, finish record and status codes.
// ---------------------------------------------------------------------------
package plip_pkg;

	// Default depth of the token queue between front and back
	localparam int PLIP_QUEUE_DEPTH = 4;

	// Characters
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_ZERO       = 8'h30;
	localparam logic [7:0] CH_NINE       = 8'h39;
	localparam logic [7:0] CH_LOW_A      = 8'h61;
	localparam logic [7:0] CH_LOW_F      = 8'h66;
	localparam logic [7:0] CH_LOW_B      = 8'h62;
	localparam logic [7:0] CH_LOW_O      = 8'h6F;
	localparam logic [7:0] CH_LOW_X      = 8'h78;
	localparam logic [7:0] CASE_BIT      = 8'h20;

	// Digit value meaning "not a digit"
	localparam logic [4:0] DIG_NONE = 5'd16;

	// Radix codes
	localparam logic [1:0] RX_DEC = 2'd0;
	localparam logic [1:0] RX_OCT = 2'd1;
	localparam logic [1:0] RX_BIN = 2'd2;
	localparam logic [1:0] RX_HEX = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [1:0] ST_RANGE     = 2'd3;

	// Target width codes
	localparam logic [1:0] WC_8  = 2'd0;
	localparam logic [1:0] WC_16 = 2'd1;
	localparam logic [1:0] WC_32 = 2'd2;
	localparam logic [1:0] WC_64 = 2'd3;

	typedef enum logic [2:0] {
		CLS_OTHER,
		CLS_UNDER,
		CLS_PLUS,
		CLS_MINUS,
		CLS_PFX_X,
		CLS_PFX_O,
		CLS_PFX_B
	} chr_cls_t;

	// One classified character
	typedef struct packed {
		chr_cls_t    cls;
		logic [4:0]  digit;
		logic        last;
		logic        mode;
		logic [1:0]  width;
	} tok_t;

	// Parser state at the end of a literal
	typedef struct packed {
		logic [63:0] mag;
		logic        neg;
		logic        mal;
		logic        saw;
		logic        ovf;
		logic        mode;
		logic [1:0]  width;
	} fin_t;

endpackage

`default_nettype wire

// ===== rtl/core/prefixed_integer_literal_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "prefixed_integer_literal_parser_defines.svh"
// ---------------------------------------------------------------------------
// prefixed_integer_literal_parser: streaming integer literal parser
//
// Input channel (in_valid/in_ready): one character item per transfer, with
// last_char on the final character. unsigned_mode is taken from the first
// item of a literal, width_code from the last. Output channel
// (out_valid/out_ready): one result item per literal, result_value and
// status (ok, malformed, 64-bit overflow, out of width range).
// Throughput: one character per cycle while the token queue has room; the
// parser consumes one queued token per cycle, holding a last token while the
// finish register is full, and multiplies by the radix with shifts and adds.
// A result passes the token queue, finish register and output register.
// A stalled receiver holds the result in the output register; the next
// literal's final state waits in the finish register, the parser keeps
// consuming characters up to the last character of the literal after that,
// and once the token queue fills in_ready drops.
// Reset clears the queue, the parser state and the output valid.
// ---------------------------------------------------------------------------
module prefixed_integer_literal_parser import plip_pkg::*; #(
	parameter int QUEUE_DEPTH = PLIP_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	input  wire logic        last_char,
	input  wire logic        unsigned_mode,
	input  wire logic [1:0]  width_code,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      result_value,
	output logic [1:0]       status
);

	logic q_ready;
	logic push;
	tok_t push_tok;
	logic pop;
	logic tok_valid;
	tok_t tok;
	logic fin_valid;
	fin_t fin;
	logic fin_take;

	plip_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.char_code     (char_code),
		.last_char     (last_char),
		.unsigned_mode (unsigned_mode),
		.width_code    (width_code),
		.q_ready       (q_ready),
		.push          (push),
		.push_tok      (push_tok)
	);

	plip_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_tok  (push_tok),
		.q_ready   (q_ready),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok       (tok)
	);

	plip_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok),
		.pop       (pop),
		.fin_valid (fin_valid),
		.fin       (fin),
		.fin_take  (fin_take)
	);

	plip_result u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.fin_valid    (fin_valid),
		.fin          (fin),
		.fin_take     (fin_take),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.status       (status)
	);

	// A failed literal never carries a value
	`PLIP_ASSERT_IMP(a_err_value_zero, clk, arst_n, out_valid && (status != ST_OK), result_value == 64'd0)
	// A held finish record is never overwritten by the next literal
	`PLIP_ASSERT_IMP(a_fin_no_clobber, clk, arst_n, fin_valid && !fin_take, !(pop && tok.last))
	// A finish record appears only after the parser consumed a last token
	`PLIP_ASSERT_IMP(a_fin_source, clk, arst_n, $rose(fin_valid), $past(pop && tok.last))

endmodule

`default_nettype wire

// ===== rtl/core/plip_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// plip_front: input classifier
// Decodes each character into a class and digit value, tracks the literal
// start to sample the conversion mode, and pushes a token into the queue.
// ---------------------------------------------------------------------------
module plip_front import plip_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] char_code,
	input  wire logic       last_char,
	input  wire logic       unsigned_mode,
	input  wire logic [1:0] width_code,
	input  wire logic       q_ready,
	output logic            push,
	output tok_t            push_tok
);

	logic       first_q;
	logic       mode_q;
	logic [7:0] low;

	assign in_ready = q_ready;
	assign push     = in_valid && q_ready;
	assign low      = char_code | CASE_BIT;

	// Character decode
	always_comb begin
		push_tok.last  = last_char;
		push_tok.width = width_code;
		push_tok.mode  = first_q ? unsigned_mode : mode_q;

		if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
			push_tok.digit = 5'(char_code - CH_ZERO);
		end else if (low >= CH_LOW_A && low <= CH_LOW_F) begin
			push_tok.digit = 5'(low - CH_LOW_A) + 5'd10;
		end else begin
			push_tok.digit = DIG_NONE;
		end

		if (char_code == CH_UNDERSCORE) begin
			push_tok.cls = CLS_UNDER;
		end else if (char_code == CH_PLUS) begin
			push_tok.cls = CLS_PLUS;
		end else if (char_code == CH_MINUS) begin
			push_tok.cls = CLS_MINUS;
		end else if (low == CH_LOW_X) begin
			push_tok.cls = CLS_PFX_X;
		end else if (low == CH_LOW_O) begin
			push_tok.cls = CLS_PFX_O;
		end else if (low == CH_LOW_B) begin
			push_tok.cls = CLS_PFX_B;
		end else begin
			push_tok.cls = CLS_OTHER;
		end
	end

	// Literal start tracking; mode is held from the first item on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			mode_q  <= 1'b0;
		end else if (push) begin
			first_q <= last_char;
			mode_q  <= push_tok.mode;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/plip_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// plip_queue: token FIFO
// Small circular queue decoupling the classifier from the parser.
// ---------------------------------------------------------------------------
module plip_queue import plip_pkg::*; #(
	parameter int DEPTH = PLIP_QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  tok_t      push_tok,
	output logic      q_ready,
	input  wire logic pop,
	output logic      tok_valid,
	output tok_t      tok
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tok_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_ready   = count_q != CNT_W'(DEPTH);
	assign tok_valid = count_q != '0;
	assign tok       = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/plip_exec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// plip_exec: literal parser
// Runs the syntax state machine and digit accumulator, one token per cycle;
// a last token waits for a free finish register, then hands it the final state.
// ---------------------------------------------------------------------------
module plip_exec import plip_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic tok_valid,
	input  tok_t      tok,
	output logic      pop,
	output logic      fin_valid,
	output fin_t      fin,
	input  wire logic fin_take
);

	typedef enum logic [4:0] {
		PH_START  = 5'b00001,
		PH_SIGN   = 5'b00010,
		PH_ZERO   = 5'b00100,
		PH_PREFIX = 5'b01000,
		PH_DIGITS = 5'b10000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [1:0]  radix_q, radix_n;
	logic        neg_q, neg_n;
	logic [63:0] mag_q, mag_n;
	logic        ovf_q, ovf_n;
	logic        mal_q, mal_n;
	logic        saw_q, saw_n;
	logic        take;
	logic [67:0] prod;
	logic [68:0] acc;
	logic        fin_valid_s1;
	fin_t        fin_s1;
	logic        fin_ready;

	function automatic logic digit_fits(input logic [1:0] rx, input logic [4:0] d);
		logic ok;
		case (rx)
			RX_DEC:  ok = d < 5'd10;
			RX_OCT:  ok = d < 5'd8;
			RX_BIN:  ok = d < 5'd2;
			RX_HEX:  ok = d < 5'd16;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	assign fin_ready = !fin_valid_s1 || fin_take;
	assign pop       = tok_valid && (!tok.last || fin_ready);
	assign fin_valid = fin_valid_s1;
	assign fin       = fin_s1;

	// Syntax state machine
	always_comb begin
		phase_n = phase_q;
		radix_n = radix_q;
		neg_n   = neg_q;
		mal_n   = mal_q;
		saw_n   = saw_q;
		take    = 1'b0;
		if (tok.cls != CLS_UNDER) begin
			case (phase_q)
				PH_START, PH_SIGN: begin
					if (phase_q == PH_START && tok.cls == CLS_PLUS) begin
						phase_n = PH_SIGN;
					end else if (phase_q == PH_START && tok.cls == CLS_MINUS) begin
						if (tok.mode) begin
							mal_n = 1'b1;
						end else begin
							neg_n = 1'b1;
						end
						phase_n = PH_SIGN;
					end else if (tok.digit == 5'd0) begin
						saw_n   = 1'b1;
						phase_n = PH_ZERO;
					end else if (tok.digit < 5'd10) begin
						radix_n = RX_DEC;
						take    = 1'b1;
					end else begin
						mal_n = 1'b1;
					end
				end
				PH_ZERO: begin
					if (tok.cls == CLS_PFX_X) begin
						radix_n = RX_HEX;
						saw_n   = 1'b0;
						phase_n = PH_PREFIX;
					end else if (tok.cls == CLS_PFX_O) begin
						radix_n = RX_OCT;
						saw_n   = 1'b0;
						phase_n = PH_PREFIX;
					end else if (tok.cls == CLS_PFX_B) begin
						radix_n = RX_BIN;
						saw_n   = 1'b0;
						phase_n = PH_PREFIX;
					end else begin
						radix_n = RX_OCT;
						if (tok.digit < 5'd8) begin
							take = 1'b1;
						end else begin
							mal_n = 1'b1;
						end
					end
				end
				default: begin
					if (digit_fits(radix_q, tok.digit)) begin
						take = 1'b1;
					end else begin
						mal_n = 1'b1;
					end
				end
			endcase
		end
		if (take) begin
			saw_n   = 1'b1;
			phase_n = PH_DIGITS;
		end
	end

	// Digit accumulator: magnitude * radix + digit, carries above bit 63 flag overflow
	always_comb begin
		case (radix_n)
			RX_DEC:  prod = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0};
			RX_OCT:  prod = {1'b0, mag_q, 3'b000};
			RX_BIN:  prod = {3'b000, mag_q, 1'b0};
			default: prod = {mag_q, 4'b0000};
		endcase
		acc   = {1'b0, prod} + 69'(tok.digit[3:0]);
		mag_n = mag_q;
		ovf_n = ovf_q;
		if (take && !ovf_q) begin
			if (acc[68:64] != '0) begin
				ovf_n = 1'b1;
			end else begin
				mag_n = acc[63:0];
			end
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			radix_q <= RX_DEC;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			ovf_q   <= 1'b0;
			mal_q   <= 1'b0;
			saw_q   <= 1'b0;
		end else if (pop) begin
			if (tok.last) begin
				phase_q <= PH_START;
				radix_q <= RX_DEC;
				neg_q   <= 1'b0;
				mag_q   <= '0;
				ovf_q   <= 1'b0;
				mal_q   <= 1'b0;
				saw_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				radix_q <= radix_n;
				neg_q   <= neg_n;
				mag_q   <= mag_n;
				ovf_q   <= ovf_n;
				mal_q   <= mal_n;
				saw_q   <= saw_n;
			end
		end
	end

	// Finish register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s1 <= 1'b0;
		end else if (pop && tok.last) begin
			fin_valid_s1 <= 1'b1;
		end else if (fin_take) begin
			fin_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && tok.last) begin
			fin_s1.mag   <= mag_n;
			fin_s1.neg   <= neg_n;
			fin_s1.mal   <= mal_n;
			fin_s1.saw   <= saw_n;
			fin_s1.ovf   <= ovf_n;
			fin_s1.mode  <= tok.mode;
			fin_s1.width <= tok.width;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/plip_result.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// plip_result: range check and output register
// Turns the final parser state into a status and signed value and holds the
// result item until the receiver takes it.
// ---------------------------------------------------------------------------
module plip_result import plip_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  fin_valid,
	input  fin_t       fin,
	output logic       fin_take,
	output logic       out_valid,
	input  wire logic  out_ready,
	output logic [63:0] result_value,
	output logic [1:0] status
);

	localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;

	logic        out_valid_q;
	logic [63:0] value_q;
	logic [1:0]  status_q;
	logic [63:0] ulim;
	logic [63:0] slim;
	logic [1:0]  st_d;
	logic [63:0] val_d;

	assign fin_take     = fin_valid && (!out_valid_q || out_ready);
	assign out_valid    = out_valid_q;
	assign result_value = value_q;
	assign status       = status_q;

	// Width limits
	always_comb begin
		case (fin.width)
			WC_8: begin
				ulim = 64'h0000_0000_0000_00FF;
				slim = 64'h0000_0000_0000_007F;
			end
			WC_16: begin
				ulim = 64'h0000_0000_0000_FFFF;
				slim = 64'h0000_0000_0000_7FFF;
			end
			WC_32: begin
				ulim = 64'h0000_0000_FFFF_FFFF;
				slim = 64'h0000_0000_7FFF_FFFF;
			end
			default: begin
				ulim = SMAX;
				slim = SMAX;
			end
		endcase
	end

	// Status and value
	always_comb begin
		if (fin.mal || !fin.saw) begin
			st_d = ST_MALFORMED;
		end else if (fin.ovf) begin
			st_d = ST_OVERFLOW;
		end else if (fin.mode) begin
			st_d = (fin.mag > ulim) ? ST_RANGE : ST_OK;
		end else if (fin.neg ? (fin.mag[63] && fin.mag[62:0] != '0) : fin.mag[63]) begin
			st_d = ST_OVERFLOW;
		end else if (fin.neg ? (fin.mag > slim + 64'd1) : (fin.mag > slim)) begin
			st_d = ST_RANGE;
		end else begin
			st_d = ST_OK;
		end
		if (st_d != ST_OK) begin
			val_d = '0;
		end else if (fin.neg) begin
			val_d = 64'd0 - fin.mag;
		end else begin
			val_d = fin.mag;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_take) begin
			value_q  <= val_d;
			status_q <= st_d;
		end
	end

endmodule

`default_nettype wire
